// ===== rtl/pps_pkg.sv =====
`timescale 1ns / 1ps
// pps_pkg: shared types and constants for the payload power sequencer
// state encodings, message codes, register indexes and reset values
// no dependencies
package pps_pkg;

  localparam int unsigned WAIT_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 32;

  typedef enum logic [3:0] {
    PL_NO_POWER   = 4'd0,
    PL_SWITCH_ON  = 4'd1,
    PL_GOOD_WAIT  = 4'd2,
    PL_XBAR_SETUP = 4'd3,
    PL_BOOTING    = 4'd4,
    PL_WORKING    = 4'd5,
    PL_SWITCH_OFF = 4'd6,
    PL_QUIESCED   = 4'd7,
    PL_FAIL       = 4'd8
  } pl_state_t;

  typedef enum logic [2:0] {
    RM_OFF        = 3'd0,
    RM_SWITCH_ON  = 3'd1,
    RM_GOOD       = 3'd2,
    RM_SWITCH_OFF = 3'd3,
    RM_QUIESCED   = 3'd4
  } rm_state_t;

  typedef enum logic [2:0] {
    MSG_SUPPLY_GOOD  = 3'd0,
    MSG_SUPPLY_LOST  = 3'd1,
    MSG_PGOOD        = 3'd2,
    MSG_PGOOD_LOST   = 3'd3,
    MSG_QUIESCE      = 3'd4,
    MSG_REAR_ON      = 3'd5,
    MSG_REAR_QUIESCE = 3'd6
  } msg_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLL_WAIT   = 2'd0,
    CFG_BOOT_SETTLE = 2'd1,
    CFG_REAR_ON     = 2'd2,
    CFG_REAR_PRESENT = 2'd3
  } cfg_idx_t;

  localparam logic [WAIT_W-1:0] POLL_WAIT_RST   = 16'd10;
  localparam logic [WAIT_W-1:0] BOOT_SETTLE_RST = 16'd1000;
  localparam logic [WAIT_W-1:0] REAR_ON_RST     = 16'd100;

  typedef struct packed {
    logic       req_type;
    logic [2:0] message_code;
    logic       fpga_done;
    logic       core_power_good;
    logic       bus_granted;
  } in_item_t;

  typedef struct packed {
    logic [WAIT_W-1:0] next_wait;
    logic              crossbar_setup_pulse;
    logic              rear_quiesced_pulse;
    logic              payload_quiesced_pulse;
    logic              rear_power_enable;
    logic              converters_enable;
    logic [2:0]        rear_status;
    logic [3:0]        payload_status;
  } out_item_t;

endpackage

// ===== rtl/payload_power_sequencer.sv =====
`timescale 1ns / 1ps
// payload_power_sequencer: payload and rear-module power sequencing machines
// input register, next-state logic, result register; uses pps_pkg
//
// channel  dir  tdata / tuser                                      handshake
// in_      in   tdata: message_code, fpga_done, core_power_good,  tvalid/tready
//               bus_granted; tuser: req_type
// out_     out  tdata: status, enables, pulses, next_wait          tvalid/tready
// cfg_     in   4 registers, index 0..3, 16-bit write data         wr_en only
//
// one beat per cycle sustained while out_tready is high; an accepted input beat
// passes through the input register, then the result register
// the state update and result are formed in one pass of the next-state logic
// reset is synchronous, active low; no clearing pass, control and state registers take defaults
// an output stall holds the result and stops the input register only when full
module payload_power_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [2:0] message_code, [3] fpga_done, [4] core_power_good, [5] bus_granted
  input  logic [pps_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] req_type
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [3:0] payload_status, [6:4] rear_status, [7] converters_enable,
  // [8] rear_power_enable, [9] payload_quiesced_pulse,
  // [10] rear_quiesced_pulse, [11] crossbar_setup_pulse, [27:12] next_wait
  output logic [pps_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [pps_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [pps_pkg::WAIT_W-1:0]       cfg_wdata
);

  // configuration
  logic [pps_pkg::WAIT_W-1:0] poll_wait_r, boot_settle_r, rear_on_wait_r;
  logic                       rear_present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_wait_r    <= pps_pkg::POLL_WAIT_RST;
      boot_settle_r  <= pps_pkg::BOOT_SETTLE_RST;
      rear_on_wait_r <= pps_pkg::REAR_ON_RST;
      rear_present_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (pps_pkg::cfg_idx_t'(cfg_addr))
        pps_pkg::CFG_POLL_WAIT:    poll_wait_r    <= cfg_wdata;
        pps_pkg::CFG_BOOT_SETTLE:  boot_settle_r  <= cfg_wdata;
        pps_pkg::CFG_REAR_ON:      rear_on_wait_r <= cfg_wdata;
        pps_pkg::CFG_REAR_PRESENT: rear_present_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register
  logic              in_vld_r;
  pps_pkg::in_item_t in_item_r;
  logic              out_vld_r;
  pps_pkg::out_item_t out_item_r, out_item_nxt;
  logic              advance;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.req_type        <= in_tuser;
      in_item_r.message_code    <= in_tdata[2:0];
      in_item_r.fpga_done       <= in_tdata[3];
      in_item_r.core_power_good <= in_tdata[4];
      in_item_r.bus_granted     <= in_tdata[5];
    end
  end

  // sequencer state
  pps_pkg::pl_state_t pl_state_r, pl_state_nxt;
  pps_pkg::rm_state_t rm_state_r, rm_state_nxt;
  logic supply_good_r, supply_good_nxt;
  logic quiesce_pend_r, quiesce_pend_nxt;
  logic rear_on_pend_r, rear_on_pend_nxt;
  logic rear_q_pend_r, rear_q_pend_nxt;
  logic conv_on_r, conv_on_nxt;
  logic rear_en_r, rear_en_nxt;
  logic pl_pulse, rm_pulse, xbar_pulse;
  logic [pps_pkg::WAIT_W-1:0] wait_nxt;

  always_comb begin
    pl_state_nxt     = pl_state_r;
    rm_state_nxt     = rm_state_r;
    supply_good_nxt  = supply_good_r;
    quiesce_pend_nxt = quiesce_pend_r;
    rear_on_pend_nxt = rear_on_pend_r;
    rear_q_pend_nxt  = rear_q_pend_r;
    conv_on_nxt      = conv_on_r;
    rear_en_nxt      = rear_en_r;
    pl_pulse         = 1'b0;
    rm_pulse         = 1'b0;
    xbar_pulse       = 1'b0;
    wait_nxt         = '0;

    if (!in_item_r.req_type) begin
      case (pps_pkg::msg_code_t'(in_item_r.message_code))
        pps_pkg::MSG_SUPPLY_GOOD:  supply_good_nxt  = 1'b1;
        pps_pkg::MSG_SUPPLY_LOST:  supply_good_nxt  = 1'b0;
        pps_pkg::MSG_QUIESCE:      quiesce_pend_nxt = 1'b1;
        pps_pkg::MSG_REAR_ON:      rear_on_pend_nxt = 1'b1;
        pps_pkg::MSG_REAR_QUIESCE: rear_q_pend_nxt  = 1'b1;
        default: ;
      endcase
    end else begin
      wait_nxt = poll_wait_r;
      case (pl_state_r)
        pps_pkg::PL_NO_POWER: begin
          if (supply_good_r) begin
            pl_state_nxt = pps_pkg::PL_SWITCH_ON;
            wait_nxt     = '0;
          end
          quiesce_pend_nxt = 1'b0;
        end
        pps_pkg::PL_SWITCH_ON: begin
          conv_on_nxt  = 1'b1;
          pl_state_nxt = pps_pkg::PL_GOOD_WAIT;
        end
        pps_pkg::PL_GOOD_WAIT: begin
          if (in_item_r.core_power_good) begin
            wait_nxt     = boot_settle_r;
            pl_state_nxt = pps_pkg::PL_XBAR_SETUP;
          end
        end
        pps_pkg::PL_XBAR_SETUP: begin
          if (in_item_r.bus_granted) begin
            xbar_pulse   = 1'b1;
            pl_state_nxt = pps_pkg::PL_BOOTING;
          end
          wait_nxt = '0;
        end
        pps_pkg::PL_BOOTING: begin
          if (quiesce_pend_r) begin
            pl_state_nxt = pps_pkg::PL_SWITCH_OFF;
            wait_nxt     = '0;
          end else if (in_item_r.fpga_done) begin
            pl_state_nxt = pps_pkg::PL_WORKING;
            wait_nxt     = '0;
          end
          quiesce_pend_nxt = 1'b0;
        end
        pps_pkg::PL_WORKING: begin
          if (quiesce_pend_r) begin
            pl_state_nxt = pps_pkg::PL_SWITCH_OFF;
            wait_nxt     = '0;
          end else if (!supply_good_r) begin
            pl_state_nxt = pps_pkg::PL_FAIL;
          end
          quiesce_pend_nxt = 1'b0;
        end
        pps_pkg::PL_SWITCH_OFF: begin
          wait_nxt         = '0;
          quiesce_pend_nxt = 1'b0;
          pl_state_nxt     = pps_pkg::PL_QUIESCED;
          conv_on_nxt      = 1'b0;
          pl_pulse         = 1'b1;
        end
        pps_pkg::PL_QUIESCED: begin
          if (!supply_good_r) pl_state_nxt = pps_pkg::PL_NO_POWER;
          quiesce_pend_nxt = 1'b0;
        end
        pps_pkg::PL_FAIL: begin
          quiesce_pend_nxt = 1'b0;
        end
        default: ;
      endcase

      if (rear_present_r) begin
        case (rm_state_r)
          pps_pkg::RM_OFF: begin
            if (rear_on_pend_r) rm_state_nxt = pps_pkg::RM_SWITCH_ON;
            rear_en_nxt     = 1'b0;
            rear_q_pend_nxt = 1'b0;
          end
          pps_pkg::RM_SWITCH_ON: begin
            rm_state_nxt = pps_pkg::RM_GOOD;
            rear_en_nxt  = 1'b1;
            if (wait_nxt == '0) wait_nxt = rear_on_wait_r;
          end
          pps_pkg::RM_GOOD: begin
            if (rear_q_pend_r) rm_state_nxt = pps_pkg::RM_SWITCH_OFF;
            else if (!supply_good_r) rm_state_nxt = pps_pkg::RM_OFF;
          end
          pps_pkg::RM_SWITCH_OFF: begin
            rm_state_nxt    = pps_pkg::RM_QUIESCED;
            rear_q_pend_nxt = 1'b0;
            rear_en_nxt     = 1'b0;
            rm_pulse        = 1'b1;
          end
          pps_pkg::RM_QUIESCED: begin
            rm_state_nxt     = pps_pkg::RM_OFF;
            rear_on_pend_nxt = 1'b0;
          end
          default: ;
        endcase
      end
    end

    out_item_nxt.payload_status         = pl_state_nxt;
    out_item_nxt.rear_status            = rm_state_nxt;
    out_item_nxt.converters_enable      = conv_on_nxt;
    out_item_nxt.rear_power_enable      = rear_en_nxt;
    out_item_nxt.payload_quiesced_pulse = pl_pulse;
    out_item_nxt.rear_quiesced_pulse    = rm_pulse;
    out_item_nxt.crossbar_setup_pulse   = xbar_pulse;
    out_item_nxt.next_wait              = wait_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl_state_r     <= pps_pkg::PL_NO_POWER;
      rm_state_r     <= pps_pkg::RM_OFF;
      supply_good_r  <= 1'b0;
      quiesce_pend_r <= 1'b0;
      rear_on_pend_r <= 1'b0;
      rear_q_pend_r  <= 1'b0;
      conv_on_r      <= 1'b0;
      rear_en_r      <= 1'b0;
    end else if (advance) begin
      pl_state_r     <= pl_state_nxt;
      rm_state_r     <= rm_state_nxt;
      supply_good_r  <= supply_good_nxt;
      quiesce_pend_r <= quiesce_pend_nxt;
      rear_on_pend_r <= rear_on_pend_nxt;
      rear_q_pend_r  <= rear_q_pend_nxt;
      conv_on_r      <= conv_on_nxt;
      rear_en_r      <= rear_en_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_item_r <= out_item_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(pps_pkg::OUT_DATA_W - $bits(pps_pkg::out_item_t)){1'b0}},
                       out_item_r};

  // checks
  a_fail_terminal: assert property (@(posedge clk) disable iff (!rst_n)
    pl_state_r == pps_pkg::PL_FAIL |=> pl_state_r == pps_pkg::PL_FAIL)
    else $error("payload left power fail");

  a_conv_level: assert property (@(posedge clk) disable iff (!rst_n)
    (pl_state_r == pps_pkg::PL_GOOD_WAIT || pl_state_r == pps_pkg::PL_XBAR_SETUP ||
     pl_state_r == pps_pkg::PL_BOOTING || pl_state_r == pps_pkg::PL_WORKING ||
     pl_state_r == pps_pkg::PL_SWITCH_OFF || pl_state_r == pps_pkg::PL_FAIL)
    |-> conv_on_r)
    else $error("converters off in a powered state");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(pl_state_r) && $stable(rm_state_r))
    else $error("state moved without a beat");

  a_xbar_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_item_r.crossbar_setup_pulse
    |-> out_item_r.payload_status == pps_pkg::PL_BOOTING)
    else $error("crossbar pulse outside booting");

  a_pl_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_item_r.payload_quiesced_pulse
    |-> out_item_r.payload_status == pps_pkg::PL_QUIESCED && !out_item_r.converters_enable)
    else $error("quiesce pulse with converters on");

endmodule
